FILE: hw/rtl/script_token_lexer_defines.svh
// ---------------------------------------------------------------------------
// Script token lexer: assertion macros
// Shared assertion helpers for the lexer modules.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define STL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define STL_ASSERT(label, prop, msg) \
  `STL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/stl_pkg.sv
// ---------------------------------------------------------------------------
// Script token lexer package
// Token codes, token and queue word types, and character classification.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  // Default configuration.
  localparam int unsigned SourceBytesDef  = 65536;
  localparam int unsigned KeywordCharsDef = 6;
  localparam int unsigned QueueDepthDef   = 4;

  // Token kinds.
  localparam logic [5:0] KindSlash  = 6'd9;
  localparam logic [5:0] KindBang   = 6'd11;
  localparam logic [5:0] KindIdent  = 6'd19;
  localparam logic [5:0] KindString = 6'd20;
  localparam logic [5:0] KindNumber = 6'd21;
  localparam logic [5:0] KindAnd    = 6'd22;
  localparam logic [5:0] KindClass  = 6'd23;
  localparam logic [5:0] KindElse   = 6'd24;
  localparam logic [5:0] KindFalse  = 6'd25;
  localparam logic [5:0] KindFor    = 6'd26;
  localparam logic [5:0] KindFun    = 6'd27;
  localparam logic [5:0] KindIf     = 6'd28;
  localparam logic [5:0] KindNil    = 6'd29;
  localparam logic [5:0] KindOr     = 6'd30;
  localparam logic [5:0] KindPrint  = 6'd31;
  localparam logic [5:0] KindReturn = 6'd32;
  localparam logic [5:0] KindSuper  = 6'd33;
  localparam logic [5:0] KindThis   = 6'd34;
  localparam logic [5:0] KindTrue   = 6'd35;
  localparam logic [5:0] KindVar    = 6'd36;
  localparam logic [5:0] KindWhile  = 6'd37;
  localparam logic [5:0] KindError  = 6'd38;
  localparam logic [5:0] KindEof    = 6'd39;

  // Error codes.
  localparam logic [1:0] ErrNone         = 2'd0;
  localparam logic [1:0] ErrUnexpected   = 2'd1;
  localparam logic [1:0] ErrUnterminated = 2'd2;

  // One token.
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [1:0]  err;
  } stl_token_t;

  // Queue word: the tokens raised by one source byte, oldest in tok0.
  typedef struct packed {
    logic       two;
    stl_token_t tok0;
    stl_token_t tok1;
  } stl_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } stl_qstat_t;

  // Keyword lookup on the first six identifier bytes, first byte in the top bits.
  function automatic logic [5:0] keyword_kind(input logic [47:0] text, input logic [2:0] len);
    logic [5:0] k;
    k = KindIdent;
    case (len)
      3'd2: begin
        if (text[47:32] == "if") k = KindIf;
        else if (text[47:32] == "or") k = KindOr;
      end
      3'd3: begin
        if (text[47:24] == "and") k = KindAnd;
        else if (text[47:24] == "for") k = KindFor;
        else if (text[47:24] == "fun") k = KindFun;
        else if (text[47:24] == "nil") k = KindNil;
        else if (text[47:24] == "var") k = KindVar;
      end
      3'd4: begin
        if (text[47:16] == "else") k = KindElse;
        else if (text[47:16] == "this") k = KindThis;
        else if (text[47:16] == "true") k = KindTrue;
      end
      3'd5: begin
        if (text[47:8] == "class") k = KindClass;
        else if (text[47:8] == "false") k = KindFalse;
        else if (text[47:8] == "print") k = KindPrint;
        else if (text[47:8] == "super") k = KindSuper;
        else if (text[47:8] == "while") k = KindWhile;
      end
      3'd6: begin
        if (text == "return") k = KindReturn;
      end
      default: k = KindIdent;
    endcase
    return k;
  endfunction

  // Single-character punctuation: valid flag over the kind.
  function automatic logic [6:0] punct_kind(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "(":     r = {1'b1, 6'd0};
      ")":     r = {1'b1, 6'd1};
      "{":     r = {1'b1, 6'd2};
      "}":     r = {1'b1, 6'd3};
      ",":     r = {1'b1, 6'd4};
      ".":     r = {1'b1, 6'd5};
      "-":     r = {1'b1, 6'd6};
      "+":     r = {1'b1, 6'd7};
      ";":     r = {1'b1, 6'd8};
      "*":     r = {1'b1, 6'd10};
      default: r = {1'b0, 6'd0};
    endcase
    return r;
  endfunction

  // Operators that may take a trailing '=': valid flag over the operator index.
  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      "!":     r = 3'b100;
      "=":     r = 3'b101;
      ">":     r = 3'b110;
      "<":     r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stl_front.sv
// ---------------------------------------------------------------------------
// Script token lexer: front end
// Takes one source byte a cycle unless the token queue is full, updates the lexer
// mode and writes the tokens that the byte completes into the queue as one word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_front #(
  parameter int unsigned SourceBytes  = stl_pkg::SourceBytesDef,
  parameter int unsigned KeywordChars = stl_pkg::KeywordCharsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [7:0]          src_byte_i,
  output      logic                full_o,
  input  wire stl_pkg::stl_qstat_t qstat_i,
  output      logic                q_push_o,
  output      stl_pkg::stl_entry_t q_entry_o
);

  localparam int unsigned PosLimitInt = (SourceBytes - 1 < 65535) ? SourceBytes - 1 : 65535;
  localparam logic [15:0] PosLimit    = 16'(PosLimitInt);
  localparam int unsigned IdxW        = $clog2(KeywordChars);

  // Lexer modes.
  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeSlash   = 3'd1;
  localparam logic [2:0] ModeOp      = 3'd2;
  localparam logic [2:0] ModeComment = 3'd3;
  localparam logic [2:0] ModeInt     = 3'd4;
  localparam logic [2:0] ModeFrac    = 3'd5;
  localparam logic [2:0] ModeIdent   = 3'd6;
  localparam logic [2:0] ModeString  = 3'd7;

  localparam logic [7:0]  ChNewline = 8'h0A;
  localparam logic [15:0] LineMax   = 16'hFFFF;
  localparam logic [2:0]  IdLenMax  = 3'd7;

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  op_q, op_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] begin_q, begin_d;
  logic [15:0] line_q, line_d;
  logic [2:0]  idlen_q, idlen_d;
  logic [7:0]  prefix_q [KeywordChars];

  logic            acc, eof, again;
  logic            digit_ch, letter_ch, is_blank;
  logic [6:0]      punct;
  logic [2:0]      opc;
  logic [15:0]     pos_inc;
  logic [5:0]      flush_kind;
  logic            flush_valid;
  logic            pre_we;
  logic [IdxW-1:0] pre_idx;
  logic            t1v, t2v;
  stl_pkg::stl_token_t t1, t2;

  assign acc    = push_i && !qstat_i.full;
  assign full_o = qstat_i.full;
  assign eof    = (src_byte_i == 8'h00);

  // Character classes of the incoming byte.
  assign digit_ch  = src_byte_i inside {["0":"9"]};
  assign letter_ch = src_byte_i inside {["a":"z"], ["A":"Z"], "_"};
  assign is_blank  = src_byte_i inside {" ", 8'h0D, 8'h09};
  assign punct     = stl_pkg::punct_kind(src_byte_i);
  assign opc       = stl_pkg::op_code(src_byte_i);

  // Next offset, held at the limit once reached.
  assign pos_inc = (pos_q < PosLimit) ? pos_q + 16'd1 : PosLimit;

  // Kind of the token pending in the current mode.
  always_comb begin
    flush_valid = 1'b1;
    case (mode_q)
      ModeSlash:           flush_kind = stl_pkg::KindSlash;
      ModeOp:              flush_kind = stl_pkg::KindBang + {3'b000, op_q, 1'b0};
      ModeInt, ModeFrac:   flush_kind = stl_pkg::KindNumber;
      ModeIdent: begin
        flush_kind = stl_pkg::keyword_kind({prefix_q[0], prefix_q[1], prefix_q[2],
                                            prefix_q[3], prefix_q[4], prefix_q[5]}, idlen_q);
      end
      ModeString:          flush_kind = stl_pkg::KindError;
      default: begin
        flush_kind  = stl_pkg::KindEof;
        flush_valid = 1'b0;
      end
    endcase
  end

  // Mode update: first close or extend the pending token, then start a new one.
  always_comb begin
    mode_d  = mode_q;
    op_d    = op_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    line_d  = line_q;
    idlen_d = idlen_q;
    pre_we  = 1'b0;
    pre_idx = '0;
    again   = 1'b0;
    t1v     = 1'b0;
    t2v     = 1'b0;
    t1 = '{kind: flush_kind, start: begin_q, length: pos_q - begin_q,
           line: line_q, err: stl_pkg::ErrNone};
    t2 = '{kind: stl_pkg::KindEof, start: pos_q, length: 16'd0,
           line: line_q, err: stl_pkg::ErrNone};
    if (acc) begin
      if (eof) begin
        // End of source: flush, emit the end token and restart.
        t1v = flush_valid;
        if (mode_q == ModeString) t1.err = stl_pkg::ErrUnterminated;
        t2v     = 1'b1;
        mode_d  = ModeIdle;
        op_d    = 2'd0;
        pos_d   = 16'd0;
        begin_d = 16'd0;
        line_d  = 16'd1;
        idlen_d = 3'd0;
      end else begin
        pos_d = pos_inc;
        case (mode_q)
          ModeSlash: begin
            if (src_byte_i == "/") begin
              mode_d = ModeComment;
            end else begin
              t1v    = 1'b1;
              mode_d = ModeIdle;
              again  = 1'b1;
            end
          end
          ModeOp: begin
            mode_d = ModeIdle;
            t1v    = 1'b1;
            if (src_byte_i == "=") begin
              t1.kind   = flush_kind + 6'd1;
              t1.length = pos_inc - begin_q;
            end else begin
              again = 1'b1;
            end
          end
          ModeComment: begin
            if (src_byte_i == ChNewline) begin
              mode_d = ModeIdle;
              again  = 1'b1;
            end
          end
          ModeInt, ModeFrac: begin
            if (digit_ch) begin
              mode_d = mode_q;
            end else if (src_byte_i == "." && mode_q == ModeInt) begin
              mode_d = ModeFrac;
            end else begin
              t1v    = 1'b1;
              mode_d = ModeIdle;
              again  = 1'b1;
            end
          end
          ModeIdent: begin
            if (letter_ch || digit_ch) begin
              if (32'(idlen_q) < KeywordChars) begin
                pre_we  = 1'b1;
                pre_idx = idlen_q[IdxW-1:0];
              end
              if (idlen_q != IdLenMax) idlen_d = idlen_q + 3'd1;
            end else begin
              t1v    = 1'b1;
              mode_d = ModeIdle;
              again  = 1'b1;
            end
          end
          ModeString: begin
            if (src_byte_i == "\"") begin
              t1v       = 1'b1;
              t1.kind   = stl_pkg::KindString;
              t1.length = pos_inc - begin_q;
              mode_d    = ModeIdle;
            end else if (src_byte_i == ChNewline && line_q != LineMax) begin
              line_d = line_q + 16'd1;
            end
          end
          default: begin
            mode_d = ModeIdle;
            again  = 1'b1;
          end
        endcase

        // Start of a new token from idle.
        if (again) begin
          if (is_blank) begin
            mode_d = ModeIdle;
          end else if (src_byte_i == ChNewline) begin
            if (line_q != LineMax) line_d = line_q + 16'd1;
          end else begin
            begin_d = pos_q;
            if (src_byte_i == "/") begin
              mode_d = ModeSlash;
            end else if (digit_ch) begin
              mode_d = ModeInt;
            end else if (letter_ch) begin
              pre_we  = 1'b1;
              pre_idx = '0;
              idlen_d = 3'd1;
              mode_d  = ModeIdent;
            end else if (src_byte_i == "\"") begin
              mode_d = ModeString;
            end else if (opc[2]) begin
              op_d   = opc[1:0];
              mode_d = ModeOp;
            end else begin
              t2v       = 1'b1;
              t2.start  = pos_q;
              t2.length = pos_inc - pos_q;
              if (punct[6]) begin
                t2.kind = punct[5:0];
              end else begin
                t2.kind = stl_pkg::KindError;
                t2.err  = stl_pkg::ErrUnexpected;
              end
            end
          end
        end
      end
    end
  end

  // Queue word for this byte.
  assign q_push_o       = t1v || t2v;
  assign q_entry_o.two  = t1v && t2v;
  assign q_entry_o.tok0 = t1v ? t1 : t2;
  assign q_entry_o.tok1 = t2;

  // Lexer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      op_q    <= 2'd0;
      pos_q   <= 16'd0;
      begin_q <= 16'd0;
      line_q  <= 16'd1;
      idlen_q <= 3'd0;
    end else begin
      mode_q  <= mode_d;
      op_q    <= op_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      line_q  <= line_d;
      idlen_q <= idlen_d;
    end
  end

  // Identifier prefix kept for the keyword check.
  always_ff @(posedge clk_i) begin
    if (pre_we) prefix_q[pre_idx] <= src_byte_i;
  end

  `STL_ASSERT(a_eof_restart, acc && eof |=> mode_q == ModeIdle && pos_q == 16'd0 && line_q == 16'd1, "lexer did not restart after end of source")
  `STL_ASSERT(a_line_nonzero, line_q != 16'd0, "line counter reached zero")

endmodule

`default_nettype wire

FILE: hw/rtl/stl_queue.sv
// ---------------------------------------------------------------------------
// Script token lexer: token queue
// Short first-in first-out store of token words between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_queue #(
  parameter int unsigned Depth = stl_pkg::QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire stl_pkg::stl_entry_t entry_i,
  input  wire logic                pop_i,
  output      stl_pkg::stl_entry_t head_o,
  output      stl_pkg::stl_qstat_t qstat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  stl_pkg::stl_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign qstat_o.full  = (count_q == CntW'(Depth));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  `STL_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue fill level above depth")

endmodule

`default_nettype wire

FILE: hw/rtl/stl_back.sv
// ---------------------------------------------------------------------------
// Script token lexer: back end
// Splits queue words into single tokens and holds the oldest in the
// result register until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_defines.svh"

module stl_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire stl_pkg::stl_qstat_t qstat_i,
  input  wire stl_pkg::stl_entry_t head_i,
  output      logic                q_pop_o,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      stl_pkg::stl_token_t token_o,
  output      logic                last_o
);

  logic                out_valid_q;
  logic                idx_q;
  logic                last_q;
  stl_pkg::stl_token_t tok_q;
  logic                load, head_last;

  // Load the next token when the result register is free or being taken.
  assign load      = !qstat_i.empty && (!out_valid_q || pop_i);
  assign head_last = !head_i.two || idx_q;
  assign q_pop_o   = load && head_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= !head_last;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= idx_q ? head_i.tok1 : head_i.tok0;
      last_q <= head_last;
    end
  end

  assign empty_o = !out_valid_q;
  assign token_o = tok_q;
  assign last_o  = last_q;

  `STL_ASSERT(a_second_waits, out_valid_q && !last_q |-> !qstat_i.empty, "second token of a word lost")
  `STL_ASSERT(a_idx_follows, idx_q |-> out_valid_q && !last_q, "word split out of step with result")

endmodule

`default_nettype wire

FILE: hw/rtl/script_token_lexer.sv
// ---------------------------------------------------------------------------
// Script token lexer
// Turns a stream of source bytes into tokens of a small scripting language.
//
//   Channel  Direction  Handshake        Words
//   source   in         push / full      src_byte_i
//   tokens   out        pop / empty      token_kind_o .. last_of_run_o
//
// Sustains one source byte per cycle while the token queue is not full; the
// mode update is a single stage. Two tokens from one byte leave one at a
// time. Up to QueueDepth (four) words wait in the token queue, one more token
// in the result register; the source side stalls only when the queue is full.
// Reset needs no clearing pass; the block accepts bytes the cycle after it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module script_token_lexer #(
  parameter int unsigned SourceBytes  = stl_pkg::SourceBytesDef,
  parameter int unsigned KeywordChars = stl_pkg::KeywordCharsDef,
  parameter int unsigned QueueDepth   = stl_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  src_byte_i,
  input  wire logic        pop,
  output      logic        empty,
  output      logic [5:0]  token_kind_o,
  output      logic [15:0] token_start_o,
  output      logic [15:0] token_length_o,
  output      logic [15:0] token_line_o,
  output      logic [1:0]  error_code_o,
  output      logic        last_of_run_o
);

  stl_pkg::stl_qstat_t qstat;
  stl_pkg::stl_entry_t q_entry, q_head;
  stl_pkg::stl_token_t token;
  logic                q_push, q_pop;

  // Byte classification and mode update.
  stl_front #(
    .SourceBytes (SourceBytes),
    .KeywordChars(KeywordChars)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .src_byte_i(src_byte_i),
    .full_o    (full),
    .qstat_i   (qstat),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  // Words between the two halves.
  stl_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .head_o (q_head),
    .qstat_o(qstat)
  );

  // Token output.
  stl_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qstat_i(qstat),
    .head_i (q_head),
    .q_pop_o(q_pop),
    .pop_i  (pop),
    .empty_o(empty),
    .token_o(token),
    .last_o (last_of_run_o)
  );

  assign token_kind_o   = token.kind;
  assign token_start_o  = token.start;
  assign token_length_o = token.length;
  assign token_line_o   = token.line;
  assign error_code_o   = token.err;

endmodule

`default_nettype wire
